// ----- design/vrlc_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants of the virtual series RLC step block.
package vrlc_pkg;

  // Fixed-point limits in Q12.20; DT_MIN_US and DT_MAX_US are in microseconds.
  localparam int DEADBAND_Q   = 157286;
  localparam int STATE_LIMIT  = 20971520;
  localparam int TORQUE_LIMIT = 125829;
  localparam int IQ_LIMIT     = 2097152;
  localparam int DT_MIN_US    = 100;
  localparam int DT_MAX_US    = 5000;
  localparam int LC_MIN       = 105;

  // Word and datapath widths.
  localparam int CFG_W      = 31;
  localparam int CFG_IDX_W  = 3;
  localparam int VEL_W      = 32;
  localparam int US_IN_W    = 32;
  localparam int US_W       = 13;
  localparam int STATE_W    = 26;
  localparam int TORQUE_W   = 18;
  localparam int IQ_W       = 23;
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 96;

  // Divider geometry: 58-bit signed dividend, 51-bit divisor, 28 quotient bits.
  localparam int DIVIDEND_W = 58;
  localparam int MAG_W      = 56;
  localparam int DIVISOR_W  = 51;
  localparam int QUOT_W     = 28;

  // Register indexes on the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RESISTANCE  = 3'd0,
    REG_INDUCTANCE  = 3'd1,
    REG_CAPACITANCE = 3'd2,
    REG_VEL_GAIN    = 3'd3,
    REG_TORQUE_GAIN = 3'd4
  } reg_idx_t;

  // Current register values.
  typedef struct packed {
    logic [CFG_W-1:0] resistance;
    logic [CFG_W-1:0] inductance;
    logic [CFG_W-1:0] capacitance;
    logic [CFG_W-1:0] velocity_gain;
    logic [CFG_W-1:0] torque_gain;
  } vrlc_cfg_t;

  // Controller states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_NUM,
    ST_MUL_B,
    ST_DIVI_GO,
    ST_DIVI_WAIT,
    ST_DIVV_GO,
    ST_DIVV_WAIT,
    ST_TQ_MUL,
    ST_TQ,
    ST_IQ_MUL,
    ST_IQ,
    ST_DONE
  } ctrl_state_t;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLEAR,
    OP_MUL_A,
    OP_NUM,
    OP_MUL_B,
    OP_DIVI_GO,
    OP_DIVI_WAIT,
    OP_DIVV_GO,
    OP_DIVV_WAIT,
    OP_TQ_MUL,
    OP_TQ,
    OP_IQ_MUL,
    OP_IQ,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_status_t;

endpackage

// ----- design/vrlc_cfg_regs.sv -----
`timescale 1ns / 1ps
// Configuration register file of the virtual RLC step block.
module vrlc_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [vrlc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vrlc_pkg::CFG_W-1:0]     cfg_data,
  output vrlc_pkg::vrlc_cfg_t           cfg
);
  import vrlc_pkg::*;

  vrlc_cfg_t        cfg_r;
  logic [CFG_W-1:0] lc_data;

  // Writes are always taken.
  assign cfg_ready = 1'b1;

  // Inductance and capacitance are only ever used with a floor of LC_MIN.
  assign lc_data = (cfg_data < CFG_W'(LC_MIN)) ? CFG_W'(LC_MIN) : cfg_data;

  // Register writes; indexes past the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.resistance    <= 31'd1572864;
      cfg_r.inductance    <= 31'd83886;
      cfg_r.capacitance   <= 31'd314573;
      cfg_r.velocity_gain <= 31'd1048576;
      cfg_r.torque_gain   <= 31'd20972;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_RESISTANCE:  cfg_r.resistance    <= cfg_data;
        REG_INDUCTANCE:  cfg_r.inductance    <= lc_data;
        REG_CAPACITANCE: cfg_r.capacitance   <= lc_data;
        REG_VEL_GAIN:    cfg_r.velocity_gain <= cfg_data;
        REG_TORQUE_GAIN: cfg_r.torque_gain   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- design/vrlc_div.sv -----
`timescale 1ns / 1ps
// Radix-2 restoring divider computing trunc(p * 2^20 / d) with overflow detection.
module vrlc_div (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic signed [vrlc_pkg::DIVIDEND_W-1:0] dividend,
  input  logic [vrlc_pkg::DIVISOR_W-1:0]        divisor,
  output logic [vrlc_pkg::QUOT_W-1:0]           quot,
  output logic                                 ovf,
  output logic                                 neg,
  output logic                                 done
);
  import vrlc_pkg::*;

  localparam int CNT_W = $clog2(QUOT_W + 1);

  logic                  chk_r;
  logic                  busy_r;
  logic                  done_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [MAG_W-1:0]      m_r;
  logic [DIVISOR_W-1:0]  d_r;
  logic                  neg_r;
  logic                  ovf_r;
  logic [DIVISOR_W-1:0]  rem_r;
  logic [QUOT_W-1:0]     bits_r;
  logic [QUOT_W-1:0]     q_r;

  logic [DIVIDEND_W-1:0] mag_w;
  logic                  ovf_w;
  logic [DIVISOR_W:0]    trial_w;
  logic [DIVISOR_W:0]    diff_w;
  logic                  ge_w;

  // Magnitude of the signed dividend; it always fits in MAG_W bits.
  assign mag_w = dividend[DIVIDEND_W-1] ? DIVIDEND_W'(-dividend) : DIVIDEND_W'(dividend);

  // The quotient needs more than QUOT_W bits exactly when m >= d * 2^8.
  assign ovf_w = {3'b000, m_r} >= {d_r, 8'h00};

  // One restoring step: bring down the next dividend bit and try a subtract.
  assign trial_w = {rem_r, bits_r[QUOT_W-1]};
  assign ge_w    = trial_w >= {1'b0, d_r};
  assign diff_w  = trial_w - {1'b0, d_r};

  // Sequencing: an overflow check, then one quotient bit per cycle unless the check finds an overflow.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_r  <= 1'b0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        chk_r  <= 1'b1;
        busy_r <= 1'b0;
      end else if (chk_r) begin
        chk_r <= 1'b0;
        if (ovf_w) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
          cnt_r  <= CNT_W'(QUOT_W);
        end
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Operand and partial remainder registers.
  always_ff @(posedge clk) begin
    if (start) begin
      m_r   <= mag_w[MAG_W-1:0];
      d_r   <= divisor;
      neg_r <= dividend[DIVIDEND_W-1];
    end else if (chk_r) begin
      ovf_r  <= ovf_w;
      rem_r  <= {3'b000, m_r[MAG_W-1:8]};
      bits_r <= {m_r[7:0], 20'h00000};
      q_r    <= '0;
    end else if (busy_r) begin
      rem_r  <= ge_w ? diff_w[DIVISOR_W-1:0] : trial_w[DIVISOR_W-1:0];
      bits_r <= {bits_r[QUOT_W-2:0], 1'b0};
      q_r    <= {q_r[QUOT_W-2:0], ge_w};
    end
  end

  assign quot = q_r;
  assign ovf  = ovf_r;
  assign neg  = neg_r;
  assign done = done_r;

endmodule

// ----- design/vrlc_dpath.sv -----
`timescale 1ns / 1ps
// Datapath of the virtual RLC step: multipliers, shared divider, state and result words.
module vrlc_dpath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  vrlc_pkg::dp_cmd_t                  cmd,
  input  vrlc_pkg::vrlc_cfg_t                cfg,
  input  logic signed [vrlc_pkg::VEL_W-1:0]  velocity,
  input  logic [vrlc_pkg::US_IN_W-1:0]       elapsed_us,
  output vrlc_pkg::dp_status_t               status,
  output logic [vrlc_pkg::OUT_DATA_W-1:0]    out_data
);
  import vrlc_pkg::*;

  localparam logic [19:0] MICRO_PER_S = 20'd1000000;
  // ceil(2^28 / 7) * 200: |torque| * 200 / 7 as a multiply and shift.
  localparam logic [32:0] IQ_RECIP    = 33'd7669584600;

  // Circuit state.
  logic signed [STATE_W-1:0]  i_r;
  logic signed [STATE_W-1:0]  vc_r;

  // Per-item working registers.
  logic signed [VEL_W-1:0]    vel_r;
  logic [US_W-1:0]            us_r;
  logic signed [63:0]         p_vin_r;
  logic signed [57:0]         p_ri_r;
  logic [DIVISOR_W-1:0]       d_l_r;
  logic [DIVISOR_W-1:0]       d_c_r;
  logic signed [43:0]         num_r;
  logic signed [57:0]         p_i_r;
  logic signed [39:0]         p_v_r;
  logic signed [57:0]         p_t_r;
  logic signed [TORQUE_W-1:0] torque_r;
  logic [21:0]                q7_r;
  logic                       tneg_r;
  logic signed [IQ_W-1:0]     iq_r;
  logic [OUT_DATA_W-1:0]      out_data_r;

  logic signed [43:0]         vin_w;
  logic signed [37:0]         ri_w;
  logic signed [37:0]         tq_w;
  logic signed [STATE_W-1:0]  ni_w;
  logic [TORQUE_W-1:0]        tmag_w;
  logic [49:0]                iqp_w;
  logic [21:0]                qs_w;
  logic signed [VEL_W-1:0]    vel_db_w;
  logic [US_W-1:0]            us_cl_w;
  logic                       div_start;
  logic signed [DIVIDEND_W-1:0] div_dividend;
  logic [DIVISOR_W-1:0]       div_divisor;
  logic [QUOT_W-1:0]          div_quot;
  logic                       div_ovf;
  logic                       div_neg;
  logic                       div_done;

  // old + signed quotient, saturated to the state limit.
  function automatic logic signed [STATE_W-1:0] sat_step(
    input logic signed [STATE_W-1:0] old,
    input logic [QUOT_W-1:0]         q,
    input logic                      ovf,
    input logic                      neg
  );
    logic signed [QUOT_W+1:0] d;
    logic signed [QUOT_W+1:0] s;
    d = $signed({2'b00, q});
    if (neg) begin
      d = -d;
    end
    s = old + d;
    if (ovf) begin
      sat_step = neg ? -STATE_W'(STATE_LIMIT) : STATE_W'(STATE_LIMIT);
    end else if (s > STATE_LIMIT) begin
      sat_step = STATE_W'(STATE_LIMIT);
    end else if (s < -STATE_LIMIT) begin
      sat_step = -STATE_W'(STATE_LIMIT);
    end else begin
      sat_step = s[STATE_W-1:0];
    end
  endfunction

  // Input conditioning: velocity deadband and elapsed time clamp.
  assign vel_db_w = (velocity <= DEADBAND_Q && velocity >= -DEADBAND_Q) ? '0 : velocity;
  always_comb begin
    if (elapsed_us < US_IN_W'(DT_MIN_US)) begin
      us_cl_w = US_W'(DT_MIN_US);
    end else if (elapsed_us > US_IN_W'(DT_MAX_US)) begin
      us_cl_w = US_W'(DT_MAX_US);
    end else begin
      us_cl_w = elapsed_us[US_W-1:0];
    end
  end

  // Floors by 2^20 are arithmetic shifts, taken as part-selects.
  assign vin_w = $signed(p_vin_r[63:20]);
  assign ri_w  = $signed(p_ri_r[57:20]);
  assign tq_w  = $signed(p_t_r[57:20]);
  assign ni_w  = -i_r;

  // Torque magnitude times the reciprocal constant for the divide by 7.
  assign tmag_w = torque_r[TORQUE_W-1] ? TORQUE_W'(-torque_r) : TORQUE_W'(torque_r);
  assign iqp_w  = tmag_w[TORQUE_W-2:0] * IQ_RECIP;
  assign qs_w   = (q7_r > 22'(IQ_LIMIT)) ? 22'(IQ_LIMIT) : q7_r;

  // Divider operand selection.
  assign div_start    = (cmd.op == OP_DIVI_GO) || (cmd.op == OP_DIVV_GO);
  assign div_dividend = (cmd.op == OP_DIVV_GO) ? $signed({{18{p_v_r[39]}}, p_v_r}) : p_i_r;
  assign div_divisor  = (cmd.op == OP_DIVV_GO) ? d_c_r : d_l_r;

  vrlc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quot     (div_quot),
    .ovf      (div_ovf),
    .neg      (div_neg),
    .done     (div_done)
  );

  // Circuit state: cleared by reset and by clear mode, stepped by the divider results.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r  <= '0;
      vc_r <= '0;
    end else begin
      case (cmd.op)
        OP_CLEAR: begin
          i_r  <= '0;
          vc_r <= '0;
        end
        OP_DIVI_WAIT: begin
          if (div_done) begin
            i_r <= sat_step(i_r, div_quot, div_ovf, div_neg);
          end
        end
        OP_DIVV_WAIT: begin
          if (div_done) begin
            vc_r <= sat_step(vc_r, div_quot, div_ovf, div_neg);
          end
        end
        default: ;
      endcase
    end
  end

  // Working registers, one operation per step.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        vel_r <= vel_db_w;
        us_r  <= us_cl_w;
      end
      OP_CLEAR: begin
        torque_r <= '0;
        iq_r     <= '0;
      end
      OP_MUL_A: begin
        p_vin_r <= vel_r * $signed({1'b0, cfg.velocity_gain});
        p_ri_r  <= $signed({1'b0, cfg.resistance}) * i_r;
        d_l_r   <= cfg.inductance * MICRO_PER_S;
        d_c_r   <= cfg.capacitance * MICRO_PER_S;
      end
      OP_NUM: begin
        num_r <= vin_w - ri_w - vc_r;
      end
      OP_MUL_B: begin
        p_i_r <= num_r * $signed({1'b0, us_r});
        p_v_r <= i_r * $signed({1'b0, us_r});
      end
      OP_TQ_MUL: begin
        p_t_r <= $signed({1'b0, cfg.torque_gain}) * ni_w;
      end
      OP_TQ: begin
        if (tq_w > TORQUE_LIMIT) begin
          torque_r <= TORQUE_W'(TORQUE_LIMIT);
        end else if (tq_w < -TORQUE_LIMIT) begin
          torque_r <= -TORQUE_W'(TORQUE_LIMIT);
        end else begin
          torque_r <= tq_w[TORQUE_W-1:0];
        end
      end
      OP_IQ_MUL: begin
        q7_r   <= iqp_w[49:28];
        tneg_r <= torque_r[TORQUE_W-1];
      end
      OP_IQ: begin
        iq_r <= tneg_r ? -$signed({1'b0, qs_w}) : $signed({1'b0, qs_w});
      end
      OP_OUT: begin
        out_data_r <= {3'b000, vc_r, i_r, torque_r, iq_r};
      end
      default: ;
    endcase
  end

  assign status.div_done = div_done;
  assign out_data        = out_data_r;

  // The circuit state never leaves its saturation band.
  a_state_band: assert property (@(posedge clk) disable iff (!rst_n)
    (i_r <= STATE_LIMIT) && (i_r >= -STATE_LIMIT) &&
    (vc_r <= STATE_LIMIT) && (vc_r >= -STATE_LIMIT))
    else $error("circuit state outside saturation band");

  // A clear leaves both state words at zero.
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_CLEAR) |=> (i_r == '0) && (vc_r == '0))
    else $error("clear did not zero the circuit state");

  // The divider only finishes while the controller is waiting for it.
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (cmd.op == OP_DIVI_WAIT) || (cmd.op == OP_DIVV_WAIT))
    else $error("divider finished outside a wait step");

  // The torque word is within its limit once computed.
  a_torque: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_TQ) |=> (torque_r <= TORQUE_LIMIT) && (torque_r >= -TORQUE_LIMIT))
    else $error("torque outside its limit");

endmodule

// ----- design/vrlc_ctrl.sv -----
`timescale 1ns / 1ps
// Controller state machine sequencing the RLC step datapath and the output word.
module vrlc_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_mode,
  output logic                   in_ready,
  input  logic                   out_ready,
  output logic                   out_valid,
  input  vrlc_pkg::dp_status_t   status,
  output vrlc_pkg::dp_cmd_t      cmd
);
  import vrlc_pkg::*;

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;
  logic        out_vld_r;
  logic        out_vld_nxt;
  logic        out_free;

  // The output register can take a word when empty or being drained.
  assign out_free = !out_vld_r || out_ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = in_mode ? ST_DONE : ST_MUL_A;
        end
      end
      ST_MUL_A:     state_nxt = ST_NUM;
      ST_NUM:       state_nxt = ST_MUL_B;
      ST_MUL_B:     state_nxt = ST_DIVI_GO;
      ST_DIVI_GO:   state_nxt = ST_DIVI_WAIT;
      ST_DIVI_WAIT: begin
        if (status.div_done) begin
          state_nxt = ST_DIVV_GO;
        end
      end
      ST_DIVV_GO:   state_nxt = ST_DIVV_WAIT;
      ST_DIVV_WAIT: begin
        if (status.div_done) begin
          state_nxt = ST_TQ_MUL;
        end
      end
      ST_TQ_MUL:    state_nxt = ST_TQ;
      ST_TQ:        state_nxt = ST_IQ_MUL;
      ST_IQ_MUL:    state_nxt = ST_IQ;
      ST_IQ:        state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // Outputs: datapath operation, input ready and output valid.
  always_comb begin
    cmd.op      = OP_NONE;
    in_ready    = 1'b0;
    out_vld_nxt = out_vld_r && !out_ready;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = in_mode ? OP_CLEAR : OP_LOAD;
        end
      end
      ST_MUL_A:     cmd.op = OP_MUL_A;
      ST_NUM:       cmd.op = OP_NUM;
      ST_MUL_B:     cmd.op = OP_MUL_B;
      ST_DIVI_GO:   cmd.op = OP_DIVI_GO;
      ST_DIVI_WAIT: cmd.op = OP_DIVI_WAIT;
      ST_DIVV_GO:   cmd.op = OP_DIVV_GO;
      ST_DIVV_WAIT: cmd.op = OP_DIVV_WAIT;
      ST_TQ_MUL:    cmd.op = OP_TQ_MUL;
      ST_TQ:        cmd.op = OP_TQ;
      ST_IQ_MUL:    cmd.op = OP_IQ_MUL;
      ST_IQ:        cmd.op = OP_IQ;
      ST_DONE: begin
        if (out_free) begin
          cmd.op      = OP_OUT;
          out_vld_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // State and output-valid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  assign out_valid = out_vld_r;

endmodule

// ----- design/virtual_rlc_haptic_step.sv -----
`timescale 1ns / 1ps
// Top level of the virtual series RLC haptic step block.
//
// Each input word carries a knob velocity and the elapsed microseconds; a stepping
// word advances a virtual series RLC circuit by one forward Euler step and returns
// one word with the q-axis current command, torque command, inductor current and
// capacitor voltage, all signed with the 20 fraction bits of Q12.20. A new word is
// accepted only once the block is back in idle. The shared radix-2 divider runs
// twice (current step, then voltage step); a run has a start step, a check step,
// one step per quotient bit for 28 bits and a step to take the result. A run whose
// quotient overflows and saturates outright skips the bit steps. Seven multiplier
// and saturation stages, the output register load and the return to idle complete
// the step. A clear word (mode set) zeroes the state and returns an all-zero word.
// One result word waits in the output register while the next input word is being
// worked on; the next result cannot be loaded until it has been taken, so a stalled
// receiver holds the block in its done state. Configuration writes take effect at
// once and are accepted in every cycle; write them only while the block is idle.
module virtual_rlc_haptic_step (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [vrlc_pkg::IN_DATA_W-1:0]      in_tdata,   // velocity[31:0], elapsed_us[63:32]
  input  logic                                in_tuser,   // mode[0]
  // Result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [vrlc_pkg::OUT_DATA_W-1:0]     out_tdata,  // phase_current_command[22:0],
                                                          // torque_command[40:23],
                                                          // circuit_current[66:41],
                                                          // capacitor_voltage[92:67], zero
  // Configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [vrlc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vrlc_pkg::CFG_W-1:0]          cfg_data
);
  import vrlc_pkg::*;

  vrlc_cfg_t               cfg;
  dp_cmd_t                 cmd;
  dp_status_t              status;
  logic signed [VEL_W-1:0] velocity;
  logic [US_IN_W-1:0]      elapsed_us;

  // Unpack the input word.
  assign velocity   = $signed(in_tdata[31:0]);
  assign elapsed_us = in_tdata[63:32];

  vrlc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  vrlc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_mode   (in_tuser),
    .in_ready  (in_tready),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .status    (status),
    .cmd       (cmd)
  );

  vrlc_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .cfg        (cfg),
    .velocity   (velocity),
    .elapsed_us (elapsed_us),
    .status     (status),
    .out_data   (out_tdata)
  );

endmodule
